### src/gcomp_pkg.sv
// ----------------------------------------------------------------------------
// gcomp_pkg
// Shared types, constants and helpers of the glyph coverage compositor.
// ----------------------------------------------------------------------------
package gcomp_pkg;

  // frame store geometry
  localparam int          FB_PIXELS   = 65536;
  localparam int          FB_AW       = $clog2(FB_PIXELS);
  localparam logic [31:0] FB_PIXELS_W = 32'(FB_PIXELS);

  // configuration port
  localparam int APB_AW = 4;

  typedef enum logic [1:0] {
    REG_FB_STRIDE     = 2'd0,
    REG_FB_HEIGHT     = 2'd1,
    REG_TEXT_COLOR    = 2'd2,
    REG_FONT_BASELINE = 2'd3
  } cfg_reg_t;

  localparam logic [10:0] FB_STRIDE_RST     = 11'd320;
  localparam logic [10:0] FB_HEIGHT_RST     = 11'd200;
  localparam logic [23:0] TEXT_COLOR_RST    = 24'hFFFFFF;
  localparam logic [7:0]  FONT_BASELINE_RST = 8'd0;

  // command codes
  typedef enum logic [2:0] {
    OP_BEGIN_TEXT = 3'd0,
    OP_GLYPH_HDR  = 3'd1,
    OP_COVERAGE   = 3'd2,
    OP_WRITE_PIX  = 3'd3,
    OP_READ_PIX   = 3'd4
  } opcode_t;

  // blend constants
  localparam logic [7:0]  CH_MAX    = 8'hFF;
  localparam logic [15:0] BLEND_RND = 16'd127;
  localparam logic [7:0]  ALPHA_OPQ = 8'hFF;

  // x / 255 for x below 65280, by shift and add
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

### src/gcomp_if.sv
// ----------------------------------------------------------------------------
// gcomp_cmd_if / gcomp_rsp_if
// Valid/ready channels for commands into and pixel words out of the compositor.
// ----------------------------------------------------------------------------
interface gcomp_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [15:0] pen_x;
  logic signed [15:0] top_y;
  logic signed [7:0]  bearing_x;
  logic signed [7:0]  bearing_y;
  logic [7:0]         glyph_width;
  logic [7:0]         glyph_height;
  logic [7:0]         advance;
  logic [7:0]         coverage;
  logic [15:0]        pixel_address;
  logic [31:0]        pixel_data;

  modport source (
    output valid, opcode, pen_x, top_y, bearing_x, bearing_y, glyph_width,
           glyph_height, advance, coverage, pixel_address, pixel_data,
    input  ready
  );
  modport sink (
    input  valid, opcode, pen_x, top_y, bearing_x, bearing_y, glyph_width,
           glyph_height, advance, coverage, pixel_address, pixel_data,
    output ready
  );
endinterface

interface gcomp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

### src/glyph_coverage_compositor_unit.sv
// ----------------------------------------------------------------------------
// glyph_coverage_compositor_unit
// RGBA8888 frame store with a coverage glyph blender and direct pixel access.
// ----------------------------------------------------------------------------
//  channel  kind       direction  carries
//  cmd      valid/rdy  in         opcode, pen/glyph metrics, coverage, pixel
//  rsp      valid/rdy  out        read_data for pixel reads
//  apb      apb write  in         fb_stride, fb_height, text_color, baseline
//
//  Begin text, glyph header, pixel write and skipped coverage finish on accept.
//  A pixel read waits in ST_RD_DATA while the previous result still sits in rsp.
//  A drawn coverage byte steps through accept, row multiply, store read, channel
//  products, divide and write back (ends after the read when past the store).
//  Reset is synchronous; the frame store itself is not cleared.
//  cmd ready is low from the cycle after an accept until that item finishes.
// ----------------------------------------------------------------------------
module glyph_coverage_compositor_unit (
  input  logic                           clk,
  input  logic                           rst,
  gcomp_cmd_if.sink                      cmd,
  gcomp_rsp_if.source                    rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gcomp_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import gcomp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CV_MUL,
    ST_CV_RD,
    ST_CV_WAIT,
    ST_CV_WR,
    ST_RD_DATA
  } state_t;

  state_t state;

  // configuration registers
  logic [10:0] fb_stride;
  logic [10:0] fb_height;
  logic [23:0] text_color;
  logic [7:0]  font_baseline;

  // text and glyph state
  logic signed [15:0] pen_pos;
  logic signed [15:0] line_top;
  logic signed [15:0] org_x;
  logic signed [15:0] org_y;
  logic [7:0]         glyph_w;
  logic [7:0]         glyph_h;
  logic [7:0]         col_cnt;
  logic [7:0]         row_cnt;

  // coverage work registers
  logic [10:0]       px_q;
  logic [10:0]       py_q;
  logic [7:0]        cov_q;
  logic [21:0]       row_base;
  logic [FB_AW-1:0]  blend_waddr;
  logic [15:0]       prod_fg [3];
  logic [15:0]       prod_bg [3];
  logic              rd_in_range;

  // frame store
  logic [31:0]       mem [FB_PIXELS];
  logic              mem_we;
  logic [FB_AW-1:0]  mem_waddr;
  logic [31:0]       mem_wdata;
  logic              mem_re;
  logic [FB_AW-1:0]  mem_raddr;
  logic [31:0]       mem_q;

  logic cmd_xfer;
  logic cfg_wr;
  assign cmd_xfer = cmd.valid && cmd.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cmd.ready = (state == ST_IDLE);
  assign pready    = 1'b1;

  // register readback
  always_comb begin
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_FB_STRIDE:     prdata = {21'b0, fb_stride};
      REG_FB_HEIGHT:     prdata = {21'b0, fb_height};
      REG_TEXT_COLOR:    prdata = {8'b0, text_color};
      REG_FONT_BASELINE: prdata = {24'b0, font_baseline};
      default:           prdata = '0;
    endcase
  end

  // glyph header arithmetic, wraps at 16 bits
  logic signed [15:0] org_x_next;
  logic signed [15:0] org_y_next;
  logic signed [15:0] pen_pos_next;
  assign org_x_next   = pen_pos + {{8{cmd.bearing_x[7]}}, cmd.bearing_x};
  assign org_y_next   = line_top + {8'b0, font_baseline}
                        - {{8{cmd.bearing_y[7]}}, cmd.bearing_y};
  assign pen_pos_next = pen_pos + {8'b0, cmd.advance};

  // coverage position, clip and raster walk
  logic [16:0] px17;
  logic [16:0] py17;
  logic        glyph_live;
  logic        in_clip;
  logic        draw;
  logic        col_end;
  assign px17 = {org_x[15], org_x} + {9'b0, col_cnt};
  assign py17 = {org_y[15], org_y} + {9'b0, row_cnt};
  assign glyph_live = (glyph_w != 8'd0) && (glyph_h != 8'd0) && (row_cnt < glyph_h);
  assign in_clip = !px17[16] && !py17[16]
                   && (px17[15:0] < {5'b0, fb_stride})
                   && (py17[15:0] < {5'b0, fb_height});
  assign draw    = glyph_live && (cmd.coverage != 8'd0) && in_clip;
  assign col_end = ({1'b0, col_cnt} + 9'd1) >= {1'b0, glyph_w};

  // store addresses
  logic [31:0] pix_addr;
  logic [31:0] blend_addr;
  logic        pix_in_range;
  logic        blend_in_range;
  assign pix_addr       = {16'b0, cmd.pixel_address};
  assign blend_addr     = {10'b0, row_base} + {21'b0, px_q};
  assign pix_in_range   = pix_addr < FB_PIXELS_W;
  assign blend_in_range = blend_addr < FB_PIXELS_W;

  // blended pixel from registered products
  logic [7:0]  blend_ch [3];
  logic [31:0] blend_pix;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blend_ch[c] = div255(prod_fg[c] + prod_bg[c] + BLEND_RND);
    end
    blend_pix = {blend_ch[2], blend_ch[1], blend_ch[0], ALPHA_OPQ};
  end

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = blend_waddr;
    mem_wdata = blend_pix;
    mem_re    = 1'b0;
    mem_raddr = blend_addr[FB_AW-1:0];
    if (state == ST_IDLE && cmd_xfer && cmd.opcode == OP_WRITE_PIX && pix_in_range) begin
      mem_we    = 1'b1;
      mem_waddr = pix_addr[FB_AW-1:0];
      mem_wdata = cmd.pixel_data;
    end
    if (state == ST_IDLE && cmd_xfer && cmd.opcode == OP_READ_PIX) begin
      mem_re    = 1'b1;
      mem_raddr = pix_addr[FB_AW-1:0];
    end
    if (state == ST_CV_RD && blend_in_range) begin
      mem_re = 1'b1;
    end
    if (state == ST_CV_WR) begin
      mem_we = 1'b1;
    end
  end

  // frame store memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fb_stride     <= FB_STRIDE_RST;
      fb_height     <= FB_HEIGHT_RST;
      text_color    <= TEXT_COLOR_RST;
      font_baseline <= FONT_BASELINE_RST;
      pen_pos       <= '0;
      line_top      <= '0;
      org_x         <= '0;
      org_y         <= '0;
      glyph_w       <= '0;
      glyph_h       <= '0;
      col_cnt       <= '0;
      row_cnt       <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr) begin
        unique case (cfg_reg_t'(paddr[3:2]))
          REG_FB_STRIDE:     fb_stride     <= pwdata[10:0];
          REG_FB_HEIGHT:     fb_height     <= pwdata[10:0];
          REG_TEXT_COLOR:    text_color    <= pwdata[23:0];
          REG_FONT_BASELINE: font_baseline <= pwdata[7:0];
          default: ;
        endcase
      end

      // response transfer frees the output register
      if (rsp.valid && rsp.ready && state != ST_RD_DATA) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_xfer) begin
            case (cmd.opcode)
              OP_BEGIN_TEXT: begin
                pen_pos  <= cmd.pen_x;
                line_top <= cmd.top_y;
              end
              OP_GLYPH_HDR: begin
                org_x   <= org_x_next;
                org_y   <= org_y_next;
                glyph_w <= cmd.glyph_width;
                glyph_h <= cmd.glyph_height;
                col_cnt <= '0;
                row_cnt <= '0;
                pen_pos <= pen_pos_next;
              end
              OP_COVERAGE: begin
                if (glyph_live) begin
                  if (col_end) begin
                    col_cnt <= '0;
                    row_cnt <= row_cnt + 8'd1;
                  end else begin
                    col_cnt <= col_cnt + 8'd1;
                  end
                end
                px_q  <= px17[10:0];
                py_q  <= py17[10:0];
                cov_q <= cmd.coverage;
                if (draw) begin
                  state <= ST_CV_MUL;
                end
              end
              OP_READ_PIX: begin
                rd_in_range <= pix_in_range;
                state       <= ST_RD_DATA;
              end
              default: ;
            endcase
          end
        end
        ST_CV_MUL: begin
          row_base <= {11'b0, py_q} * {11'b0, fb_stride};
          state    <= ST_CV_RD;
        end
        ST_CV_RD: begin
          blend_waddr <= blend_addr[FB_AW-1:0];
          state       <= blend_in_range ? ST_CV_WAIT : ST_IDLE;
        end
        ST_CV_WAIT: begin
          for (int c = 0; c < 3; c++) begin
            prod_fg[c] <= text_color[8*c +: 8] * cov_q;
            prod_bg[c] <= mem_q[8*c+8 +: 8] * (CH_MAX - cov_q);
          end
          state <= ST_CV_WR;
        end
        ST_CV_WR: begin
          state <= ST_IDLE;
        end
        ST_RD_DATA: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.read_data <= rd_in_range ? mem_q : 32'd0;
            rsp.valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // raster walk stays inside the glyph
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_cnt <= glyph_h)
    else $error("row counter past glyph height");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (col_cnt < glyph_w) || (col_cnt == 8'd0))
    else $error("column counter past glyph width");

  // a store read is followed by its consumer
  a_rd_follow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CV_RD) |=> (state == ST_CV_WAIT) || (state == ST_IDLE))
    else $error("blend read not followed by product stage");

  // responses come only from a pixel read
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == ST_RD_DATA))
    else $error("response without pixel read");

  // blend write back only targets the address that was read
  a_wb_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CV_WR) |-> (mem_waddr == $past(mem_raddr, 2)))
    else $error("blend write back address mismatch");

endmodule
